// ===== rtl/length_prefixed_record_deframer_top_assert.svh =====
// Assertion macros for the length-prefixed record deframer.
// Included by lprd_core, which carries concurrent assertions; needs no package.
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lprd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LPRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lprd assertion failed");
`else
`define LPRD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPRD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lprd_pkg.sv =====
// Package for the length-prefixed record deframer: widths, character codes,
// phase and role encodings and the result struct. Depends on nothing.
`default_nettype none

package lprd_pkg;

    localparam int LEN_W             = 20;
    localparam int BYTE_W            = 8;
    localparam int ROLE_W            = 3;
    localparam int LENGTH_DIGITS_DEF = 10;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = {LEN_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_DIGITS   = 3'd0,
        PH_SPACE    = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_AFTER    = 3'd3,
        PH_AFTER_CR = 3'd4,
        PH_DEAD     = 3'd5
    } t_phase;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_DIGIT     = 3'd0,
        ROLE_SEP       = 3'd1,
        ROLE_PAYLOAD   = 3'd2,
        ROLE_LINE_END  = 3'd3,
        ROLE_BAD_DIGIT = 3'd4,
        ROLE_NO_SPACE  = 3'd5,
        ROLE_TOO_LONG  = 3'd6,
        ROLE_DROPPED   = 3'd7
    } t_role;

    typedef struct packed {
        t_role              role;
        logic [BYTE_W-1:0]  payload;
        logic [LEN_W-1:0]   length;
        logic               rec_end;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lprd_core.sv =====
// Deframing state machine: holds the phase, digit count, length accumulator
// and payload counter, and forms the result for one byte. Uses lprd_pkg.
`default_nettype none
`include "length_prefixed_record_deframer_top_assert.svh"

module lprd_core #(
    parameter int LENGTH_DIGITS = lprd_pkg::LENGTH_DIGITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [lprd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [lprd_pkg::LEN_W-1:0]  i_max_len,
    output lprd_pkg::t_result               o_result
);
    import lprd_pkg::*;

    localparam int CNT_W = $clog2(LENGTH_DIGITS + 1);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic [LEN_W-1:0]   r_rem, n_rem;

    logic               restart;
    logic [CNT_W-1:0]   cnt_base;
    logic [CNT_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   acc_base;
    logic               ovf_base;
    logic               is_digit;
    logic [LEN_W+3:0]   acc_wide;
    logic [LEN_W+3:0]   acc_next;
    logic [LEN_W-1:0]   rem_dec;

    // A new length field starts from zero after a record or a CR.
    assign restart  = (r_phase == PH_AFTER) || (r_phase == PH_AFTER_CR);
    assign cnt_base = restart ? '0 : r_cnt;
    assign acc_base = restart ? '0 : r_acc;
    assign ovf_base = restart ? 1'b0 : r_ovf;
    assign cnt_inc  = cnt_base + CNT_W'(1);

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign acc_wide = {4'b0000, acc_base};
    // Times ten as eight plus two, then the digit value.
    assign acc_next = (acc_wide << 3) + (acc_wide << 1)
                    + {{(LEN_W-4){1'b0}}, i_byte - CH_ZERO};
    assign rem_dec  = (r_rem != '0) ? (r_rem - LEN_W'(1)) : r_rem;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_rem    = r_rem;
        o_result = '{role: ROLE_DROPPED, payload: '0, length: '0, rec_end: 1'b0};
        case (r_phase)
            PH_DIGITS, PH_AFTER, PH_AFTER_CR: begin
                if ((r_phase == PH_AFTER || r_phase == PH_AFTER_CR) && i_byte == CH_LF) begin
                    n_phase = PH_DIGITS;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    o_result.role = ROLE_LINE_END;
                end else if (r_phase == PH_AFTER && i_byte == CH_CR) begin
                    n_phase = PH_AFTER_CR;
                    o_result.role = ROLE_LINE_END;
                end else if (!is_digit) begin
                    n_phase = PH_DEAD;
                    n_cnt   = cnt_base;
                    n_acc   = acc_base;
                    n_ovf   = ovf_base;
                    o_result.role = ROLE_BAD_DIGIT;
                end else begin
                    n_cnt   = cnt_inc;
                    n_acc   = acc_next[LEN_W-1:0];
                    n_ovf   = ovf_base | (|acc_next[LEN_W+3:LEN_W]);
                    n_phase = (cnt_inc >= CNT_W'(LENGTH_DIGITS)) ? PH_SPACE : PH_DIGITS;
                    o_result.role = ROLE_DIGIT;
                end
            end
            PH_SPACE: begin
                if (i_byte != CH_SPACE) begin
                    n_phase = PH_DEAD;
                    o_result.role = ROLE_NO_SPACE;
                end else if (r_ovf || (r_acc > i_max_len)) begin
                    n_phase = PH_DEAD;
                    o_result.role = ROLE_TOO_LONG;
                end else if (r_acc == '0) begin
                    n_phase = PH_AFTER;
                    o_result.role    = ROLE_SEP;
                    o_result.rec_end = 1'b1;
                end else begin
                    n_rem   = r_acc;
                    n_phase = PH_PAYLOAD;
                    o_result.role   = ROLE_SEP;
                    o_result.length = r_acc;
                end
            end
            PH_PAYLOAD: begin
                n_rem = rem_dec;
                o_result.role    = ROLE_PAYLOAD;
                o_result.payload = i_byte;
                if (rem_dec == '0) begin
                    n_phase = PH_AFTER;
                    o_result.rec_end = 1'b1;
                end
            end
            default: begin
                n_phase = PH_DEAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DIGITS;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_rem   <= n_rem;
        end
    end

    // Once an error is flagged the stream is dead until reset.
    `LPRD_ASSERT_NXT(a_dead_sticks, i_clk, i_rst_n, r_phase == PH_DEAD, r_phase == PH_DEAD)
    // A record in progress always has at least one payload byte left.
    `LPRD_ASSERT_IMP(a_rem_nonzero, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_rem != '0)
    // The digit count never reaches the field width while digits are expected.
    `LPRD_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_phase == PH_DIGITS,
                     r_cnt < CNT_W'(LENGTH_DIGITS))

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_record_deframer_top.sv =====
// Channel       | Direction | Handshake                | Payload
// input bytes   | in        | i_in_valid / o_in_ready  | i_in_byte
// results       | out       | o_out_valid / i_out_ready| role, payload, length, end
// configuration | in        | i_cfg_valid / o_cfg_ready| i_cfg_max_record_length
//
// One byte can be accepted every cycle while intake is not held up by a waiting result.
// A byte is held in the byte register, and its result is offered from the result register.
// The byte register and the result register form a two-stage pipeline around the
// single-pass deframing logic in lprd_core, so a waiting result never stops intake
// while the input stage is empty; with both stages full, intake waits for the result.
// Reset is synchronous and active low; it clears the phase, counters and valid flags
// and sets the maximum length to all ones.
// Top level of the deframer; uses lprd_pkg and lprd_core.
`default_nettype none

module length_prefixed_record_deframer_top #(
    parameter int LENGTH_DIGITS = lprd_pkg::LENGTH_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic [lprd_pkg::BYTE_W-1:0] i_in_byte,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic [lprd_pkg::ROLE_W-1:0] o_byte_role,
    output      logic [lprd_pkg::BYTE_W-1:0] o_payload_byte,
    output      logic [lprd_pkg::LEN_W-1:0]  o_record_length,
    output      logic                        o_record_end,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [lprd_pkg::LEN_W-1:0]  i_cfg_max_record_length
);
    import lprd_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_result            r_out;
    logic [LEN_W-1:0]   r_max_len;
    logic               proc;
    t_result            n_out;

    // The buffered byte is processed when the result register is free or draining.
    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign o_cfg_ready = 1'b1;

    lprd_core #(
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (proc),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_max_record_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_role     = r_out.role;
    assign o_payload_byte  = r_out.payload;
    assign o_record_length = r_out.length;
    assign o_record_end    = r_out.rec_end;

endmodule

`default_nettype wire

// ===== bench/tb_length_prefixed_record_deframer_top.sv =====
// Self-checking bench for the length-prefixed record deframer: drives framed byte
// streams under several maximum-length settings and checks every result item.
// Depends on lprd_pkg and length_prefixed_record_deframer_top.
module tb_length_prefixed_record_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lprd_pkg::*;

    localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_W) - 64'd1;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_LIMIT = 2000;

    // Tracks the deframer state and holds the result items that are still owed.
    class role_scoreboard;
        t_phase           phase;
        logic [3:0]       digits;
        logic [LEN_W-1:0] acc;
        bit               overflow;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] max_len;
        t_result          expected_roles[$];
        int unsigned      failures;

        function new();
            max_len = MAX_LEN_RESET;
            phase = PH_DIGITS;
            restart_length();
            remaining = '0;
            failures = 0;
        endfunction

        function void restart_length();
            digits = '0;
            acc = '0;
            overflow = 1'b0;
        endfunction

        function void set_max(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_roles.size();
        endfunction

        function t_result digit_step(logic [BYTE_W-1:0] b);
            t_result r;
            logic [63:0] grown;
            r = '0;
            if (b < CH_ZERO || b > CH_NINE) begin
                phase = PH_DEAD;
                r.role = ROLE_BAD_DIGIT;
                return r;
            end
            grown = {44'd0, acc} * 64'd10 + {56'd0, b - CH_ZERO};
            // A value wider than the length field counts as too long later on.
            if (grown > LEN_LIMIT) overflow = 1'b1;
            acc = grown[LEN_W-1:0];
            digits = digits + 4'd1;
            phase = (digits >= LENGTH_DIGITS_DEF) ? PH_SPACE : PH_DIGITS;
            r.role = ROLE_DIGIT;
            return r;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_result r;
            r = '0;
            case (phase)
                PH_DIGITS: r = digit_step(b);
                PH_SPACE: begin
                    if (b != CH_SPACE) begin
                        phase = PH_DEAD;
                        r.role = ROLE_NO_SPACE;
                    end else if (overflow || acc > max_len) begin
                        phase = PH_DEAD;
                        r.role = ROLE_TOO_LONG;
                    end else if (acc == '0) begin
                        phase = PH_AFTER;
                        r.role = ROLE_SEP;
                        r.rec_end = 1'b1;
                    end else begin
                        remaining = acc;
                        phase = PH_PAYLOAD;
                        r.role = ROLE_SEP;
                        r.length = acc;
                    end
                end
                PH_PAYLOAD: begin
                    if (remaining != '0) remaining = remaining - LEN_W'(1);
                    r.role = ROLE_PAYLOAD;
                    r.payload = b;
                    if (remaining == '0) begin
                        phase = PH_AFTER;
                        r.rec_end = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (b == CH_LF) begin
                        restart_length();
                        phase = PH_DIGITS;
                        r.role = ROLE_LINE_END;
                    end else if (b == CH_CR) begin
                        phase = PH_AFTER_CR;
                        r.role = ROLE_LINE_END;
                    end else begin
                        restart_length();
                        r = digit_step(b);
                    end
                end
                PH_AFTER_CR: begin
                    restart_length();
                    if (b == CH_LF) begin
                        phase = PH_DIGITS;
                        r.role = ROLE_LINE_END;
                    end else begin
                        r = digit_step(b);
                    end
                end
                default: begin
                    phase = PH_DEAD;
                    r.role = ROLE_DROPPED;
                end
            endcase
            expected_roles.insert(expected_roles.size(), r);
        endfunction

        function void check_role(t_result got);
            t_result e;
            if (expected_roles.size() == 0) begin
                $error("unexpected result item: byte_role %0d", got.role);
                failures++;
                return;
            end
            e = expected_roles.pop_front();
            if (got.role !== e.role) begin
                $error("byte_role: expected %0d, actual %0d", e.role, got.role);
                failures++;
            end
            if (got.payload !== e.payload) begin
                $error("payload_byte: expected %0d, actual %0d", e.payload, got.payload);
                failures++;
            end
            if (got.length !== e.length) begin
                $error("record_length: expected %0d, actual %0d", e.length, got.length);
                failures++;
            end
            if (got.rec_end !== e.rec_end) begin
                $error("record_end: expected %0d, actual %0d", e.rec_end, got.rec_end);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic out_ready;
    logic cfg_valid;
    logic [LEN_W-1:0] cfg_max;

    logic o_in_ready;
    logic o_out_valid;
    logic [ROLE_W-1:0] o_byte_role;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [LEN_W-1:0] o_record_length;
    logic o_record_end;
    logic o_cfg_ready;

    role_scoreboard sb;
    int send_gap_pct = 38;
    int recv_stall_pct = 47;
    int recv_hold_cycles = 0;
    int unsigned bytes_sent = 0;
    logic [LEN_W-1:0] cur_max = MAX_LEN_RESET;

    length_prefixed_record_deframer_top u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (in_valid),
        .o_in_ready              (o_in_ready),
        .i_in_byte               (in_byte),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (out_ready),
        .o_byte_role             (o_byte_role),
        .o_payload_byte          (o_payload_byte),
        .o_record_length         (o_record_length),
        .o_record_end            (o_record_end),
        .i_cfg_valid             (cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_max_record_length (cfg_max)
    );

    always #5ns i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_length_field(input longint unsigned v);
        logic [BYTE_W-1:0] digs[LENGTH_DIGITS_DEF];
        for (int i = 0; i < LENGTH_DIGITS_DEF; i++) begin
            digs[i] = CH_ZERO + 8'(v % 10);
            v = v / 10;
        end
        for (int i = LENGTH_DIGITS_DEF - 1; i >= 0; i--) send_byte(digs[i]);
    endtask

    task automatic send_record(input int unsigned len);
        send_length_field(len);
        send_byte(CH_SPACE);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
            0: send_byte(CH_LF);
            1: send_byte(CH_CR);
            2: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            default: ;
        endcase
    endtask

    // Mostly short payloads, with zero and the capped maximum as regular picks.
    function automatic int unsigned pick_length();
        int unsigned cap;
        cap = (cur_max > 24) ? 24 : int'(cur_max);
        if (cur_max >= 200 && $urandom_range(0, 29) == 0) cap = 200;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return cap;
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    task automatic send_records(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_record(pick_length());
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_max <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_max(v);
        cur_max = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Any format error leaves the block dropping bytes until reset, so one error
    // closes the run, followed by bytes that must all come back as dropped.
    task automatic send_error_tail();
        int err_kind;
        int n;
        logic [BYTE_W-1:0] b;
        err_kind = $urandom_range(0, 3);
        case (err_kind)
            0: begin
                n = $urandom_range(0, LENGTH_DIGITS_DEF - 1);
                repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) ||
                       (n == 0 && (b == CH_LF || b == CH_CR)));
                send_byte(b);
            end
            1: begin
                repeat (LENGTH_DIGITS_DEF) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
                send_byte(b);
            end
            2: begin
                send_length_field(longint'(cur_max) + 1 + $urandom_range(0, 50));
                send_byte(CH_SPACE);
            end
            default: begin
                repeat (LENGTH_DIGITS_DEF) send_byte(CH_NINE);
                send_byte(CH_SPACE);
            end
        endcase
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note_byte(in_byte);
            if (o_out_valid && out_ready) begin
                got.role = t_role'(o_byte_role);
                got.payload = o_payload_byte;
                got.length = o_record_length;
                got.rec_end = o_record_end;
                sb.check_role(got);
            end
        end
    end

    initial begin : receiver
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (recv_hold_cycles) @(negedge i_clk);
                recv_hold_cycles = 0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        cfg_valid = 1'b0;
        cfg_max = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero-length record closed by LF, then a short record closed by a lone CR
        // whose following byte is the first digit of the next length field.
        send_length_field(0);
        send_byte(CH_SPACE);
        send_byte(CH_LF);
        send_length_field(2);
        send_byte(CH_SPACE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_records(250);

        wait_drained();
        write_max('0);
        send_records(150);

        wait_drained();
        send_gap_pct = 47;
        recv_stall_pct = 38;
        write_max(MAX_LEN_RESET);
        // The receiver holds off while bytes keep coming, so the input side stalls.
        recv_hold_cycles = 80;
        send_records(300);

        wait_drained();
        write_max(LEN_W'($urandom_range(1, 60)));
        send_records(120);
        wait_drained();
        send_records(130);

        wait_drained();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_max(LEN_W'($urandom_range(61, 1000)));
        send_records(250);
        send_error_tail();

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES * 4) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
